// ----- sv/rasi_pkg.sv -----
`timescale 1ns / 1ps

package rasi_pkg;

	localparam int MAX_TILES = 64;
	localparam int IDX_W = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
	localparam int CNT_W = $clog2(MAX_TILES + 1);

	localparam int TGT_W = 16;
	localparam int TID_W = 16;
	localparam int SER_W = 24;
	localparam int PSID_W = 13;
	localparam int ENTRY_W = TGT_W + TID_W;

	localparam int CELLS_PER_PIXEL = 3200;
	localparam int ROWS_PER_PIXEL = 50;
	localparam int COLS_PER_PIXEL = 64;
	localparam int PIXELS_PER_TILE_SH = 6;
	localparam int MAX_DIE = 15;
	localparam int MAX_PIXEL = 3;

	// Pixel serial is {rank, die, pixel}; a cell offset is below 3200.
	localparam int PS_W = IDX_W + 6;
	localparam int CELL_W = 12;

	typedef enum logic [1:0] {
		CMD_LOAD,
		CMD_CELL,
		CMD_PIXEL,
		CMD_REVERSE
	} cmd_t;

	typedef enum logic [2:0] {
		STS_OK,
		STS_UNKNOWN,
		STS_BAD_DIE,
		STS_BAD_PIXEL,
		STS_BAD_ROW,
		STS_BAD_COL,
		STS_RANGE,
		STS_FULL
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_SCAN,
		S_DRAIN,
		S_DECIDE,
		S_SHIFT,
		S_SHDRAIN,
		S_INSERT,
		S_REV,
		S_MUL,
		S_OUT
	} state_t;

	typedef struct packed {
		logic             start;
		logic             is_cell;
		logic [IDX_W-1:0] rank;
		logic [3:0]       die;
		logic [1:0]       pix;
		logic [5:0]       col;
		logic [5:0]       row;
	} ser_req_t;

endpackage

// ----- sv/rasi_ram.sv -----
`timescale 1ns / 1ps

module rasi_ram #(
	parameter int W = 32,
	parameter int DEPTH = 64,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [W-1:0]  wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [W-1:0]  rd_data
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- sv/rasi_serial.sv -----
`timescale 1ns / 1ps

module rasi_serial (
	input  logic                     clk,
	input  logic                     arst_n,
	input  rasi_pkg::ser_req_t       req,
	output logic                     done,
	output logic [rasi_pkg::SER_W-1:0] serial
);

	logic [rasi_pkg::PS_W-1:0]                    ps;
	logic [rasi_pkg::PS_W+rasi_pkg::CELL_W-1:0]   prod;
	logic [rasi_pkg::CELL_W-1:0]                  cell_off;

	logic                          vld_s1;
	logic                          vld_s2;
	logic                          is_cell_s1;
	logic [rasi_pkg::SER_W-1:0]    prod_s1;
	logic [rasi_pkg::CELL_W-1:0]   cell_s1;
	logic [rasi_pkg::PS_W-1:0]     ps_s1;
	logic [rasi_pkg::SER_W-1:0]    serial_s2;

	assign ps = {req.rank, req.die, req.pix};
	assign prod = (rasi_pkg::PS_W + rasi_pkg::CELL_W)'(ps)
		* (rasi_pkg::PS_W + rasi_pkg::CELL_W)'(rasi_pkg::CELLS_PER_PIXEL);
	// Columns are the slow index inside a pixel, rows the fast one.
	assign cell_off = rasi_pkg::CELL_W'(req.col) * rasi_pkg::CELL_W'(rasi_pkg::ROWS_PER_PIXEL)
		+ rasi_pkg::CELL_W'(req.row);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= req.start;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		is_cell_s1 <= req.is_cell;
		prod_s1 <= rasi_pkg::SER_W'(prod);
		cell_s1 <= cell_off;
		ps_s1 <= ps;
		serial_s2 <= is_cell_s1 ? (prod_s1 + rasi_pkg::SER_W'(cell_s1))
			: rasi_pkg::SER_W'(ps_s1);
	end

	assign done = vld_s2;
	assign serial = serial_s2;

endmodule

// ----- sv/readout_address_to_serial_id_top.sv -----
`timescale 1ns / 1ps
// A lookup or load reads the table once per stored tile, a cell or pixel lookup then
// goes through the multiply and add, and a load that inserts in the middle moves each
// entry above its rank up by one. A reverse lookup reads a single table entry, and range
// errors found from the fields alone finish without reading the table.
// One transaction is worked at a time; the table's single read port sets the rate.
// Reset clears the tile count and the control state; table contents are not cleared.

module readout_address_to_serial_id_top (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [15:0] tile_target,
	input  logic [15:0] tile_id,
	input  logic [4:0]  die_index,
	input  logic [7:0]  cell_column,
	input  logic [6:0]  cell_row,
	input  logic [2:0]  pixel_in_die,
	input  logic [12:0] pixel_serial,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [23:0] serial_id,
	output logic [15:0] found_target,
	output logic [3:0]  found_die,
	output logic [1:0]  found_pixel,
	output logic [15:0] found_tile_id
);

	localparam int IDX_W = rasi_pkg::IDX_W;
	localparam int CNT_W = rasi_pkg::CNT_W;
	localparam int RNG_W = (CNT_W + rasi_pkg::PIXELS_PER_TILE_SH > rasi_pkg::PSID_W)
		? CNT_W + rasi_pkg::PIXELS_PER_TILE_SH : rasi_pkg::PSID_W;

	rasi_pkg::state_t state_q, state_d;

	rasi_pkg::cmd_t cmd_q;
	logic [15:0] tgt_q;
	logic [15:0] tid_q;
	logic [4:0]  die_q;
	logic [7:0]  col_q;
	logic [6:0]  row_q;
	logic [2:0]  pix_q;
	logic [12:0] psid_q;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic             cmp_vld_s1;
	logic [IDX_W-1:0] cmp_idx_s1;
	logic             found_q;
	logic [IDX_W-1:0] slot_q;
	logic [CNT_W-1:0] lt_q;
	logic [15:0]      id_hit_q;
	logic [IDX_W-1:0] sh_idx_q;
	logic             sh_vld_s1;
	logic [IDX_W-1:0] sh_idx_s1;

	rasi_pkg::status_t res_status_q;
	logic [23:0] res_serial_q;
	logic [15:0] res_ftarget_q;
	logic [3:0]  res_fdie_q;
	logic [1:0]  res_fpix_q;
	logic [15:0] res_ftid_q;

	logic              out_valid_q;
	rasi_pkg::status_t status_q;
	logic [23:0]       serial_q;
	logic [15:0]       ftarget_q;
	logic [3:0]        fdie_q;
	logic [1:0]        fpix_q;
	logic [15:0]       ftid_q;

	logic                          ram_wr_en;
	logic [IDX_W-1:0]              ram_wr_addr;
	logic [rasi_pkg::ENTRY_W-1:0]  ram_wr_data;
	logic                          ram_rd_en;
	logic [IDX_W-1:0]              ram_rd_addr;
	logic [rasi_pkg::ENTRY_W-1:0]  ram_rd_data;
	logic [15:0]                   rd_tgt;
	logic [15:0]                   rd_tid;

	rasi_pkg::ser_req_t ser_req;
	logic               ser_done;
	logic [23:0]        ser_serial;

	logic              accept;
	logic              out_load;
	logic              row_bad;
	logic              col_bad;
	logic              pix_bad;
	logic              die_bad;
	logic              row_hi;
	logic [5:0]        row_mod;
	logic [1:0]        pin;
	logic              early_err;
	rasi_pkg::status_t early_sts;
	logic              rev_oob;
	logic              scan_last;
	logic              not_full;
	logic              lookup_ok;

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == rasi_pkg::S_IDLE);
	assign out_load = (state_q == rasi_pkg::S_OUT) && (!out_valid_q || out_ready);

	assign rd_tgt = ram_rd_data[rasi_pkg::ENTRY_W-1 -: 16];
	assign rd_tid = ram_rd_data[15:0];

	assign row_bad = row_q >= 7'(2 * rasi_pkg::ROWS_PER_PIXEL);
	assign col_bad = col_q >= 8'(2 * rasi_pkg::COLS_PER_PIXEL);
	assign pix_bad = pix_q > 3'(rasi_pkg::MAX_PIXEL);
	assign die_bad = die_q > 5'(rasi_pkg::MAX_DIE);
	assign row_hi = row_q >= 7'(rasi_pkg::ROWS_PER_PIXEL);
	assign row_mod = row_hi ? 6'(row_q - 7'(rasi_pkg::ROWS_PER_PIXEL)) : 6'(row_q);
	// Snake order: the left column of pixels runs upward, the right one downward.
	assign pin = {col_q[6], ~(col_q[6] ^ row_hi)};
	assign rev_oob = RNG_W'(psid_q)
		>= RNG_W'({count_q, {rasi_pkg::PIXELS_PER_TILE_SH{1'b0}}});
	assign scan_last = rd_idx_q == CNT_W'(count_q - 1'b1);
	assign not_full = count_q < CNT_W'(rasi_pkg::MAX_TILES);
	assign lookup_ok = found_q && !die_bad;

	always_comb begin
		early_err = 1'b0;
		early_sts = rasi_pkg::STS_OK;
		case (cmd_q)
			rasi_pkg::CMD_CELL: begin
				if (row_bad) begin
					early_err = 1'b1;
					early_sts = rasi_pkg::STS_BAD_ROW;
				end else if (col_bad) begin
					early_err = 1'b1;
					early_sts = rasi_pkg::STS_BAD_COL;
				end
			end
			rasi_pkg::CMD_PIXEL: begin
				if (pix_bad) begin
					early_err = 1'b1;
					early_sts = rasi_pkg::STS_BAD_PIXEL;
				end
			end
			default: begin
				early_err = 1'b0;
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			rasi_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = rasi_pkg::S_START;
				end
			end
			rasi_pkg::S_START: begin
				if (cmd_q == rasi_pkg::CMD_REVERSE) begin
					state_d = rev_oob ? rasi_pkg::S_OUT : rasi_pkg::S_REV;
				end else if (early_err) begin
					state_d = rasi_pkg::S_OUT;
				end else if (count_q == '0) begin
					state_d = rasi_pkg::S_DECIDE;
				end else begin
					state_d = rasi_pkg::S_SCAN;
				end
			end
			rasi_pkg::S_SCAN: begin
				if (scan_last) begin
					state_d = rasi_pkg::S_DRAIN;
				end
			end
			rasi_pkg::S_DRAIN: begin
				state_d = rasi_pkg::S_DECIDE;
			end
			rasi_pkg::S_DECIDE: begin
				if (cmd_q == rasi_pkg::CMD_LOAD) begin
					if (found_q || !not_full) begin
						state_d = rasi_pkg::S_OUT;
					end else if (lt_q == count_q) begin
						state_d = rasi_pkg::S_INSERT;
					end else begin
						state_d = rasi_pkg::S_SHIFT;
					end
				end else begin
					state_d = lookup_ok ? rasi_pkg::S_MUL : rasi_pkg::S_OUT;
				end
			end
			rasi_pkg::S_SHIFT: begin
				if (sh_idx_q == lt_q[IDX_W-1:0]) begin
					state_d = rasi_pkg::S_SHDRAIN;
				end
			end
			rasi_pkg::S_SHDRAIN: begin
				state_d = rasi_pkg::S_INSERT;
			end
			rasi_pkg::S_INSERT: begin
				state_d = rasi_pkg::S_OUT;
			end
			rasi_pkg::S_REV: begin
				state_d = rasi_pkg::S_OUT;
			end
			rasi_pkg::S_MUL: begin
				if (ser_done) begin
					state_d = rasi_pkg::S_OUT;
				end
			end
			rasi_pkg::S_OUT: begin
				if (!out_valid_q || out_ready) begin
					state_d = rasi_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = rasi_pkg::S_IDLE;
			end
		endcase
	end

	// Table port and multiplier controls.
	always_comb begin
		ram_rd_en = 1'b0;
		ram_rd_addr = rd_idx_q[IDX_W-1:0];
		ram_wr_en = 1'b0;
		ram_wr_addr = lt_q[IDX_W-1:0];
		ram_wr_data = {tgt_q, tid_q};
		ser_req.start = 1'b0;
		ser_req.is_cell = (cmd_q == rasi_pkg::CMD_CELL);
		ser_req.rank = lt_q[IDX_W-1:0];
		ser_req.die = die_q[3:0];
		ser_req.pix = (cmd_q == rasi_pkg::CMD_CELL) ? pin : pix_q[1:0];
		ser_req.col = col_q[5:0];
		ser_req.row = row_mod;
		case (state_q)
			rasi_pkg::S_START: begin
				ram_rd_en = (cmd_q == rasi_pkg::CMD_REVERSE) && !rev_oob;
				ram_rd_addr = IDX_W'(psid_q >> rasi_pkg::PIXELS_PER_TILE_SH);
			end
			rasi_pkg::S_SCAN: begin
				ram_rd_en = 1'b1;
			end
			rasi_pkg::S_DECIDE: begin
				if (cmd_q == rasi_pkg::CMD_LOAD) begin
					ram_wr_en = found_q;
					ram_wr_addr = slot_q;
				end else if (cmd_q != rasi_pkg::CMD_REVERSE) begin
					ser_req.start = lookup_ok;
				end
			end
			rasi_pkg::S_SHIFT: begin
				ram_rd_en = 1'b1;
				ram_rd_addr = sh_idx_q;
				ram_wr_en = sh_vld_s1;
				ram_wr_addr = IDX_W'(sh_idx_s1 + 1'b1);
				ram_wr_data = ram_rd_data;
			end
			rasi_pkg::S_SHDRAIN: begin
				ram_wr_en = 1'b1;
				ram_wr_addr = IDX_W'(sh_idx_s1 + 1'b1);
				ram_wr_data = ram_rd_data;
			end
			rasi_pkg::S_INSERT: begin
				ram_wr_en = 1'b1;
			end
			default: begin
				ram_rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rasi_pkg::S_IDLE;
			count_q <= '0;
			cmp_vld_s1 <= 1'b0;
			sh_vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cmp_vld_s1 <= (state_q == rasi_pkg::S_SCAN);
			sh_vld_s1 <= (state_q == rasi_pkg::S_SHIFT);
			if (state_q == rasi_pkg::S_INSERT) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= rd_idx_q[IDX_W-1:0];
		sh_idx_s1 <= sh_idx_q;

		if (accept) begin
			cmd_q <= rasi_pkg::cmd_t'(cmd);
			tgt_q <= tile_target;
			tid_q <= tile_id;
			die_q <= die_index;
			col_q <= cell_column;
			row_q <= cell_row;
			pix_q <= pixel_in_die;
			psid_q <= pixel_serial;
			rd_idx_q <= '0;
			lt_q <= '0;
			found_q <= 1'b0;
			res_status_q <= rasi_pkg::STS_OK;
			res_serial_q <= '0;
			res_ftarget_q <= '0;
			res_fdie_q <= '0;
			res_fpix_q <= '0;
			res_ftid_q <= '0;
		end

		if (state_q == rasi_pkg::S_SCAN) begin
			rd_idx_q <= CNT_W'(rd_idx_q + 1'b1);
		end

		// Targets in the table are unique, so at most one entry hits.
		if (cmp_vld_s1) begin
			if (rd_tgt == tgt_q) begin
				found_q <= 1'b1;
				slot_q <= cmp_idx_s1;
				id_hit_q <= rd_tid;
			end
			if (rd_tgt < tgt_q) begin
				lt_q <= CNT_W'(lt_q + 1'b1);
			end
		end

		case (state_q)
			rasi_pkg::S_START: begin
				if (cmd_q == rasi_pkg::CMD_REVERSE) begin
					if (rev_oob) begin
						res_status_q <= rasi_pkg::STS_RANGE;
					end
				end else if (early_err) begin
					res_status_q <= early_sts;
				end
			end
			rasi_pkg::S_DECIDE: begin
				// The table is kept sorted, so a new target goes in at its rank.
				sh_idx_q <= IDX_W'(count_q - 1'b1);
				if (cmd_q == rasi_pkg::CMD_LOAD) begin
					if (found_q || not_full) begin
						res_ftid_q <= tid_q;
					end else begin
						res_status_q <= rasi_pkg::STS_FULL;
					end
				end else if (!found_q) begin
					res_status_q <= rasi_pkg::STS_UNKNOWN;
				end else if (die_bad) begin
					res_status_q <= rasi_pkg::STS_BAD_DIE;
				end else begin
					res_ftid_q <= id_hit_q;
				end
			end
			rasi_pkg::S_SHIFT: begin
				sh_idx_q <= IDX_W'(sh_idx_q - 1'b1);
			end
			rasi_pkg::S_REV: begin
				res_ftarget_q <= rd_tgt;
				res_ftid_q <= rd_tid;
				res_fdie_q <= psid_q[5:2];
				res_fpix_q <= psid_q[1:0];
				res_serial_q <= 24'(psid_q);
			end
			rasi_pkg::S_MUL: begin
				if (ser_done) begin
					res_serial_q <= ser_serial;
				end
			end
			default: begin
			end
		endcase

		if (out_load) begin
			status_q <= res_status_q;
			serial_q <= res_serial_q;
			ftarget_q <= res_ftarget_q;
			fdie_q <= res_fdie_q;
			fpix_q <= res_fpix_q;
			ftid_q <= res_ftid_q;
		end
	end

	rasi_ram #(
		.W(rasi_pkg::ENTRY_W),
		.DEPTH(rasi_pkg::MAX_TILES),
		.AW(IDX_W)
	) u_table (
		.clk(clk),
		.wr_en(ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en(ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	rasi_serial u_serial (
		.clk(clk),
		.arst_n(arst_n),
		.req(ser_req),
		.done(ser_done),
		.serial(ser_serial)
	);

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign serial_id = serial_q;
	assign found_target = ftarget_q;
	assign found_die = fdie_q;
	assign found_pixel = fpix_q;
	assign found_tile_id = ftid_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(rasi_pkg::MAX_TILES))
		else $error("tile count beyond table size");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (count_q == CNT_W'($past(count_q) + 1'b1)))
		else $error("tile count changed by other than one");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && (res_status_q == rasi_pkg::STS_FULL))
			|-> (count_q == CNT_W'(rasi_pkg::MAX_TILES)))
		else $error("table full reported with free entries");

	a_mul_done: assert property (@(posedge clk) disable iff (!arst_n)
		ser_done |-> (state_q == rasi_pkg::S_MUL))
		else $error("serial result outside multiply state");

endmodule

// ----- verif/readout_address_to_serial_id_top_test.sv -----
`timescale 1ns / 1ps

module readout_address_to_serial_id_top_test;

	localparam int LOAD_PCT = 12;
	localparam int RANDOM_ITEMS = 1825;
	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int DIES_PER_TILE = rasi_pkg::MAX_DIE + 1;
	localparam int PIXELS_PER_DIE = rasi_pkg::MAX_PIXEL + 1;

	typedef struct packed {
		rasi_pkg::cmd_t cmd;
		logic [15:0]    target;
		logic [15:0]    tid;
		logic [4:0]     die;
		logic [7:0]     col;
		logic [6:0]     row;
		logic [2:0]     pix;
		logic [12:0]    psid;
	} tile_req_t;

	typedef struct packed {
		rasi_pkg::status_t status;
		logic [23:0]       serial;
		logic [15:0]       target;
		logic [3:0]        die;
		logic [1:0]        pix;
		logic [15:0]       tid;
	} tile_res_t;

	typedef struct {
		tile_req_t         req;
		bit                typed;
		rasi_pkg::status_t st;
		logic [23:0]       ser;
		logic [15:0]       tid;
	} step_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  cmd = '0;
	logic [15:0] tile_target = '0;
	logic [15:0] tile_id = '0;
	logic [4:0]  die_index = '0;
	logic [7:0]  cell_column = '0;
	logic [6:0]  cell_row = '0;
	logic [2:0]  pixel_in_die = '0;
	logic [12:0] pixel_serial = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [23:0] serial_id;
	logic [15:0] found_target;
	logic [3:0]  found_die;
	logic [1:0]  found_pixel;
	logic [15:0] found_tile_id;

	// Mirror of the tile table, in load order.
	logic [15:0] known_target [rasi_pkg::MAX_TILES];
	logic [15:0] known_id [rasi_pkg::MAX_TILES];
	int unsigned tiles_held = 0;

	tile_res_t pending [$];
	tile_res_t want;
	step_t     plan [$];
	int        errors = 0;
	int        quiet = 0;
	bit        steady = 1'b0;

	readout_address_to_serial_id_top u_top (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int find_slot(logic [15:0] tgt);
		for (int i = 0; i < tiles_held; i++)
			if (known_target[i] == tgt)
				return i;
		return -1;
	endfunction

	function automatic int rank_below(logic [15:0] tgt);
		int n = 0;
		for (int i = 0; i < tiles_held; i++)
			if (known_target[i] < tgt)
				n++;
		return n;
	endfunction

	// Updates the table mirror and returns the result the block must give.
	function automatic tile_res_t resolve_request(tile_req_t r);
		tile_res_t res;
		int slot;
		int pin;
		int cell_ofs;
		int ps;
		res = '0;
		slot = find_slot(r.target);
		pin = 0;
		cell_ofs = 0;
		case (r.cmd)
			rasi_pkg::CMD_LOAD: begin
				if (slot >= 0) begin
					known_id[slot] = r.tid;
					res.tid = r.tid;
				end else if (tiles_held < rasi_pkg::MAX_TILES) begin
					known_target[tiles_held] = r.target;
					known_id[tiles_held] = r.tid;
					tiles_held++;
					res.tid = r.tid;
				end else begin
					res.status = rasi_pkg::STS_FULL;
				end
			end
			rasi_pkg::CMD_CELL, rasi_pkg::CMD_PIXEL: begin
				if (r.cmd == rasi_pkg::CMD_CELL) begin
					if (r.row >= 2 * rasi_pkg::ROWS_PER_PIXEL)
						res.status = rasi_pkg::STS_BAD_ROW;
					else if (r.col >= 2 * rasi_pkg::COLS_PER_PIXEL)
						res.status = rasi_pkg::STS_BAD_COL;
					// Pixels snake through the die: left column bottom-up, right column top-down.
					if (r.col < rasi_pkg::COLS_PER_PIXEL)
						pin = (r.row < rasi_pkg::ROWS_PER_PIXEL) ? 1 : 0;
					else
						pin = (r.row < rasi_pkg::ROWS_PER_PIXEL) ? 2 : 3;
					cell_ofs = (r.col % rasi_pkg::COLS_PER_PIXEL) * rasi_pkg::ROWS_PER_PIXEL
						+ r.row % rasi_pkg::ROWS_PER_PIXEL;
				end else begin
					pin = r.pix;
					if (r.pix > rasi_pkg::MAX_PIXEL)
						res.status = rasi_pkg::STS_BAD_PIXEL;
				end
				if (res.status == rasi_pkg::STS_OK) begin
					if (slot < 0) begin
						res.status = rasi_pkg::STS_UNKNOWN;
					end else if (r.die > rasi_pkg::MAX_DIE) begin
						res.status = rasi_pkg::STS_BAD_DIE;
					end else begin
						ps = (rank_below(r.target) * DIES_PER_TILE + r.die) * PIXELS_PER_DIE
							+ pin;
						res.tid = known_id[slot];
						res.serial = (r.cmd == rasi_pkg::CMD_CELL)
							? 24'(ps * rasi_pkg::CELLS_PER_PIXEL + cell_ofs) : 24'(ps);
					end
				end
			end
			default: begin
				if (r.psid >= (tiles_held << rasi_pkg::PIXELS_PER_TILE_SH)) begin
					res.status = rasi_pkg::STS_RANGE;
				end else begin
					for (int i = 0; i < tiles_held; i++) begin
						if (rank_below(known_target[i])
								== (r.psid >> rasi_pkg::PIXELS_PER_TILE_SH)) begin
							res.target = known_target[i];
							res.tid = known_id[i];
						end
					end
					res.pix = 2'(r.psid % PIXELS_PER_DIE);
					res.die = 4'((r.psid / PIXELS_PER_DIE) % DIES_PER_TILE);
					res.serial = 24'(r.psid);
				end
			end
		endcase
		return res;
	endfunction

	function automatic int mostly_valid(int vmax, int fmax);
		return ($urandom_range(0, 99) < 85) ? $urandom_range(0, vmax)
			: $urandom_range(vmax + 1, fmax);
	endfunction

	function automatic tile_req_t random_request();
		tile_req_t r;
		r.cmd = ($urandom_range(0, 99) < LOAD_PCT) ? rasi_pkg::CMD_LOAD
			: rasi_pkg::cmd_t'($urandom_range(1, 3));
		// Loads mostly bring new targets; lookups mostly hit stored ones.
		if (tiles_held > 0 && $urandom_range(0, 99) < ((r.cmd == rasi_pkg::CMD_LOAD) ? 30 : 80))
			r.target = known_target[$urandom_range(0, tiles_held - 1)];
		else
			r.target = 16'($urandom);
		r.tid = 16'($urandom);
		r.die = 5'(mostly_valid(rasi_pkg::MAX_DIE, 31));
		r.col = 8'(mostly_valid(2 * rasi_pkg::COLS_PER_PIXEL - 1, 255));
		r.row = 7'(mostly_valid(2 * rasi_pkg::ROWS_PER_PIXEL - 1, 127));
		r.pix = 3'(mostly_valid(rasi_pkg::MAX_PIXEL, 7));
		if (tiles_held > 0 && $urandom_range(0, 99) < 80)
			r.psid = 13'($urandom_range(0, (tiles_held << rasi_pkg::PIXELS_PER_TILE_SH) - 1));
		else
			r.psid = 13'($urandom);
		return r;
	endfunction

	function automatic step_t plan_step(rasi_pkg::cmd_t c, int tgt, int id, int die, int col,
			int rw, int px, int ps, bit typed = 1'b0, rasi_pkg::status_t st = rasi_pkg::STS_OK,
			int ser = 0, int etid = 0);
		step_t s;
		s.req.cmd = c;
		s.req.target = 16'(tgt);
		s.req.tid = 16'(id);
		s.req.die = 5'(die);
		s.req.col = 8'(col);
		s.req.row = 7'(rw);
		s.req.pix = 3'(px);
		s.req.psid = 13'(ps);
		s.typed = typed;
		s.st = st;
		s.ser = 24'(ser);
		s.tid = 16'(etid);
		return s;
	endfunction

	task automatic drive_item(step_t s);
		int gap;
		tile_res_t res;
		gap = steady ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= s.req.cmd;
		tile_target <= s.req.target;
		tile_id <= s.req.tid;
		die_index <= s.req.die;
		cell_column <= s.req.col;
		cell_row <= s.req.row;
		pixel_in_die <= s.req.pix;
		pixel_serial <= s.req.psid;
		do @(posedge clk); while (!in_ready);
		res = resolve_request(s.req);
		if (s.typed) begin
			res = '0;
			res.status = s.st;
			res.serial = s.ser;
			res.tid = s.tid;
		end
		pending.push_back(res);
	endtask

	initial begin
		step_t s;
		plan.push_back(plan_step(rasi_pkg::CMD_REVERSE, 0, 0, 0, 0, 0, 0, 0,
			1, rasi_pkg::STS_RANGE));
		plan.push_back(plan_step(rasi_pkg::CMD_CELL, 'h1234, 0, 0, 0, 0, 0, 0,
			1, rasi_pkg::STS_UNKNOWN));
		plan.push_back(plan_step(rasi_pkg::CMD_PIXEL, 0, 0, 0, 0, 0, 7, 0,
			1, rasi_pkg::STS_BAD_PIXEL));
		plan.push_back(plan_step(rasi_pkg::CMD_CELL, 0, 0, 0, 255, 127, 0, 0,
			1, rasi_pkg::STS_BAD_ROW));
		plan.push_back(plan_step(rasi_pkg::CMD_CELL, 0, 0, 0, 128, 99, 0, 0,
			1, rasi_pkg::STS_BAD_COL));
		plan.push_back(plan_step(rasi_pkg::CMD_LOAD, 'h8000, 'hABCD, 0, 0, 0, 0, 0,
			1, rasi_pkg::STS_OK, 0, 'hABCD));
		plan.push_back(plan_step(rasi_pkg::CMD_LOAD, 0, 1, 0, 0, 0, 0, 0,
			1, rasi_pkg::STS_OK, 0, 1));
		plan.push_back(plan_step(rasi_pkg::CMD_LOAD, 'hFFFF, 'hFFFF, 0, 0, 0, 0, 0,
			1, rasi_pkg::STS_OK, 0, 'hFFFF));
		plan.push_back(plan_step(rasi_pkg::CMD_LOAD, 'h8000, 'h5555, 0, 0, 0, 0, 0,
			1, rasi_pkg::STS_OK, 0, 'h5555));
		plan.push_back(plan_step(rasi_pkg::CMD_PIXEL, 0, 0, 0, 0, 0, 0, 0,
			1, rasi_pkg::STS_OK, 0, 1));
		plan.push_back(plan_step(rasi_pkg::CMD_PIXEL, 'hFFFF, 0, 15, 0, 0, 3, 0,
			1, rasi_pkg::STS_OK, 191, 'hFFFF));
		plan.push_back(plan_step(rasi_pkg::CMD_PIXEL, 'h8000, 0, 16, 0, 0, 0, 0,
			1, rasi_pkg::STS_BAD_DIE));
		plan.push_back(plan_step(rasi_pkg::CMD_PIXEL, 'h1234, 0, 31, 0, 0, 0, 0,
			1, rasi_pkg::STS_UNKNOWN));
		plan.push_back(plan_step(rasi_pkg::CMD_PIXEL, 'h8000, 0, 31, 0, 0, 7, 0,
			1, rasi_pkg::STS_BAD_PIXEL));
		// One cell in each pixel of the die, to cover the snake order.
		plan.push_back(plan_step(rasi_pkg::CMD_CELL, 0, 0, 0, 0, 0, 0, 0));
		plan.push_back(plan_step(rasi_pkg::CMD_CELL, 0, 0, 0, 0, 50, 0, 0));
		plan.push_back(plan_step(rasi_pkg::CMD_CELL, 'h8000, 0, 7, 64, 0, 0, 0));
		plan.push_back(plan_step(rasi_pkg::CMD_CELL, 'hFFFF, 0, 15, 127, 99, 0, 0));
		plan.push_back(plan_step(rasi_pkg::CMD_CELL, 'h8000, 0, 31, 10, 10, 0, 0,
			1, rasi_pkg::STS_BAD_DIE));
		plan.push_back(plan_step(rasi_pkg::CMD_CELL, 'h1234, 0, 31, 200, 20, 0, 0,
			1, rasi_pkg::STS_BAD_COL));
		plan.push_back(plan_step(rasi_pkg::CMD_REVERSE, 0, 0, 0, 0, 0, 0, 0));
		plan.push_back(plan_step(rasi_pkg::CMD_REVERSE, 0, 0, 0, 0, 0, 0, 191));
		plan.push_back(plan_step(rasi_pkg::CMD_REVERSE, 0, 0, 0, 0, 0, 0, 192,
			1, rasi_pkg::STS_RANGE));
		plan.push_back(plan_step(rasi_pkg::CMD_REVERSE, 0, 0, 0, 0, 0, 0, 8191,
			1, rasi_pkg::STS_RANGE));
		plan.push_back(plan_step(rasi_pkg::CMD_PIXEL, 'h8000, 0, 5, 0, 0, 2, 0));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			drive_item(plan[i]);

		// Let the directed part drain completely before random traffic starts.
		in_valid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);

		s = plan_step(rasi_pkg::CMD_LOAD, 0, 0, 0, 0, 0, 0, 0);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			steady = (n >= 900 && n < 1100);
			if (n == 600) begin
				in_valid <= 1'b0;
				while (pending.size() != 0) @(posedge clk);
			end
			s.req = random_request();
			drive_item(s);
		end

		in_valid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int stall;
		int taken;
		taken = 0;
		while (!arst_n) @(posedge clk);
		forever begin
			// Two long holds back up the block so that it stalls its input.
			if (taken == 400 || taken == 1200)
				stall = HOLD_CYCLES;
			else if (steady)
				stall = 0;
			else
				stall = $urandom_range(0, 4);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
		if (act !== exp) begin
			$error("%s: expected %0h, got %0h", name, exp, act);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending.size() == 0) begin
				$error("result transaction with nothing expected");
				errors++;
			end else begin
				want = pending.pop_front();
				check_field("status", 32'(want.status), 32'(status));
				check_field("serial_id", 32'(want.serial), 32'(serial_id));
				check_field("found_target", 32'(want.target), 32'(found_target));
				check_field("found_die", 32'(want.die), 32'(found_die));
				check_field("found_pixel", 32'(want.pix), 32'(found_pixel));
				check_field("found_tile_id", 32'(want.tid), 32'(found_tile_id));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet = 0;
		else
			quiet = quiet + 1;
		if (quiet == QUIET_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

endmodule

// ----- filelist.f -----
sv/rasi_pkg.sv
sv/rasi_ram.sv
sv/rasi_serial.sv
sv/readout_address_to_serial_id_top.sv
verif/readout_address_to_serial_id_top_test.sv
